FILE: sv/dpo_pkg.sv
// Shared types, register indexes and fixed-point helpers for the delayed
// position observer. No dependencies; imported by the top level.
package dpo_pkg;

  typedef struct packed {
    logic signed [31:0] acceleration;
    logic signed [31:0] measured_position;
  } dpo_in_t;

  typedef struct packed {
    logic signed [31:0] position_estimate;
    logic signed [31:0] velocity_estimate;
    logic signed [31:0] bias_estimate;
  } dpo_out_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgSamplePeriod = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGainPosition = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainVelocity = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGainBias     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBiasDecay    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDelaySteps   = 3'd5;

  localparam logic [15:0] SamplePeriodRst = 16'd655;

  localparam logic signed [51:0] SatMax = 52'sd2147483647;
  localparam logic signed [51:0] SatMin = -52'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
    logic signed [31:0] r;
    if (x > SatMax) begin
      r = 32'sh7fffffff;
    end else if (x < SatMin) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [49:0] rnd16(input logic signed [65:0] x);
    logic signed [65:0] y;
    y = x + 66'sd32768;
    return y[65:16];
  endfunction

  function automatic logic signed [49:0] rnd17(input logic signed [65:0] x);
    logic signed [65:0] y;
    y = x + 66'sd65536;
    return {y[65], y[65:17]};
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [49:0] b);
    logic signed [51:0] s;
    s = {{20{a[31]}}, a} + {{2{b[49]}}, b};
    return sat32(s);
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [49:0] b);
    logic signed [51:0] s;
    s = {{20{a[31]}}, a} - {{2{b[49]}}, b};
    return sat32(s);
  endfunction

  function automatic logic signed [31:0] sat_rnd16(input logic signed [65:0] x);
    logic signed [49:0] r;
    r = rnd16(x);
    return sat32({{2{r[49]}}, r});
  endfunction

endpackage

FILE: sv/dpo_ring.sv
// Ring of past position estimates: one-port-write, one-port-read memory with
// registered read data and per-entry valid bits. No package dependencies.
module dpo_ring #(
  parameter int Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [31:0]                                wr_data_i,
  input  logic                                       rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [31:0]                                rd_data_o
);

  logic [31:0]      mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [31:0]      rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data_o = rvld_q ? rdata_q : 32'd0;

endmodule

FILE: sv/delayed_position_observer_top.sv
// Top level of the delayed position observer: sequencer, shared multiplier,
// state registers and output beat register. Depends on dpo_pkg and dpo_ring.
//
// Each accepted beat runs the sequencer StAcc..StOut before its result
// enters the output register; a new beat is accepted in the cycle the
// result is written there, so an output stall stalls the input. Ten products
// share one registered 33x33 multiplier in steps StAcc..StKbDt except
// StErr, with the chains prediction -> ring lookup -> correction in between.
// The ring of MAX_DELAY past estimates sits in a memory read in StAcc,
// ahead of use in StErr; per-entry valid bits cleared at reset make
// unwritten entries read as zero, so no clearing pass is needed after reset.
module delayed_position_observer_top #(
  parameter int MAX_DELAY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  dpo_pkg::dpo_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dpo_pkg::dpo_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [dpo_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [dpo_pkg::CfgDataW-1:0]      cfg_data_i
);
  import dpo_pkg::*;

  localparam int IdxW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;

  localparam logic [3:0] StAcc    = 4'd0;
  localparam logic [3:0] StDecay  = 4'd1;
  localparam logic [3:0] StPos    = 4'd2;
  localparam logic [3:0] StBias   = 4'd3;
  localparam logic [3:0] StErr    = 4'd4;
  localparam logic [3:0] StGp     = 4'd5;
  localparam logic [3:0] StGv     = 4'd6;
  localparam logic [3:0] StKpDt   = 4'd7;
  localparam logic [3:0] StGb     = 4'd8;
  localparam logic [3:0] StKvDt   = 4'd9;
  localparam logic [3:0] StKbDt   = 4'd10;
  localparam logic [3:0] StBFix   = 4'd11;
  localparam logic [3:0] StOut    = 4'd12;

  logic [15:0]        dt_q;
  logic signed [31:0] gp_q, gv_q, gb_q, wa_q;
  logic [3:0]         delay_q;

  logic               busy_q;
  logic [3:0]         step_q;
  logic [IdxW-1:0]    ri_q;

  logic signed [31:0] p_q, v_q, b_q;
  logic signed [31:0] acc_q, meas_q;
  logic signed [31:0] u_q, k_q, e_q, kx_q, ky_q;
  logic signed [65:0] prod_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [32:0] dt_s;

  logic               out_valid_q;
  dpo_out_t           out_data_q;

  logic [IdxW-1:0]    d_eff;
  logic [IdxW:0]      ri_inc;
  logic [IdxW-1:0]    ri_nxt;
  logic [31:0]        ring_rdata;
  logic signed [31:0] past;

  logic               in_acc, fin;

  assign fin    = busy_q && (step_q == StOut) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q && !fin;
  assign in_acc = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    if (int'(delay_q) > MAX_DELAY - 1) begin
      d_eff = IdxW'(MAX_DELAY - 1);
    end else begin
      d_eff = IdxW'(delay_q);
    end
  end

  assign ri_inc = {1'b0, ri_q} + (IdxW + 1)'(1);
  assign ri_nxt = ((ri_inc > {1'b0, d_eff}) || (int'(ri_inc) >= MAX_DELAY)) ?
                  '0 : ri_inc[IdxW-1:0];

  assign past = (ri_nxt == ri_q) ? p_q : ring_rdata;

  dpo_ring #(
    .Depth (MAX_DELAY)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (busy_q && (step_q == StErr)),
    .wr_addr_i (ri_q),
    .wr_data_i (p_q),
    .rd_en_i   (busy_q && (step_q == StAcc)),
    .rd_addr_i (ri_nxt),
    .rd_data_o (ring_rdata)
  );

  assign dt_s = {17'd0, dt_q};

  always_comb begin
    mul_a = dt_s;
    mul_b = '0;
    case (step_q)
      StAcc:   mul_b = {acc_q[31], acc_q};
      StDecay: mul_b = {wa_q[31], wa_q};
      StPos:   mul_b = {u_q[31], u_q};
      StBias: begin
        mul_a = {k_q[31], k_q};
        mul_b = {b_q[31], b_q};
      end
      StGp: begin
        mul_a = {gp_q[31], gp_q};
        mul_b = {e_q[31], e_q};
      end
      StGv: begin
        mul_a = {gv_q[31], gv_q};
        mul_b = {e_q[31], e_q};
      end
      StKpDt:  mul_b = {kx_q[31], kx_q};
      StGb: begin
        mul_a = {gb_q[31], gb_q};
        mul_b = {e_q[31], e_q};
      end
      StKvDt:  mul_b = {ky_q[31], ky_q};
      StKbDt:  mul_b = {kx_q[31], kx_q};
      default: mul_b = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q    <= SamplePeriodRst;
      gp_q    <= '0;
      gv_q    <= '0;
      gb_q    <= '0;
      wa_q    <= '0;
      delay_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSamplePeriod: dt_q    <= cfg_data_i[15:0];
        CfgGainPosition: gp_q    <= cfg_data_i;
        CfgGainVelocity: gv_q    <= cfg_data_i;
        CfgGainBias:     gb_q    <= cfg_data_i;
        CfgBiasDecay:    wa_q    <= cfg_data_i;
        CfgDelaySteps:   delay_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= StAcc;
      ri_q        <= '0;
      p_q         <= '0;
      v_q         <= '0;
      b_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (fin) begin
        busy_q <= 1'b0;
      end
      if (in_acc) begin
        step_q <= StAcc;
      end else if (busy_q && (step_q != StOut)) begin
        step_q <= step_q + 4'd1;
      end
      if (busy_q) begin
        case (step_q)
          StAcc: ;
          StDecay: v_q <= add_sat(v_q, rnd16(prod_q));
          StBias:  p_q <= add_sat(p_q, rnd16(prod_q));
          StErr: begin
            b_q  <= sub_sat(b_q, rnd16(prod_q));
            ri_q <= ri_nxt;
          end
          StGb:    p_q <= add_sat(p_q, rnd16(prod_q));
          StKbDt:  v_q <= add_sat(v_q, rnd16(prod_q));
          StBFix:  b_q <= add_sat(b_q, rnd16(prod_q));
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      acc_q  <= in_data_i.acceleration;
      meas_q <= in_data_i.measured_position;
    end
    if (busy_q) begin
      case (step_q)
        StDecay: u_q  <= add_sat(v_q, rnd17(prod_q));
        StPos:   k_q  <= sat_rnd16(prod_q);
        StErr:   e_q  <= sub_sat(meas_q, {{18{past[31]}}, past});
        StGv:    kx_q <= sat_rnd16(prod_q);
        StKpDt:  ky_q <= sat_rnd16(prod_q);
        StKvDt:  kx_q <= sat_rnd16(prod_q);
        default: ;
      endcase
    end
    if (fin) begin
      out_data_q.position_estimate <= p_q;
      out_data_q.velocity_estimate <= v_q;
      out_data_q.bias_estimate     <= b_q;
    end
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= StOut))
    else $error("sequencer step beyond output step");

  a_accept_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (!busy_q || (step_q == StOut)))
    else $error("beat accepted while an item is still in work");

  a_fin_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> out_valid_o)
    else $error("finished item did not reach the output register");

  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(ri_q) < MAX_DELAY)
    else $error("ring index outside the ring");

endmodule

FILE: verif/delayed_position_observer_top_tb.sv
// Self-checking testbench for delayed_position_observer_top: directed and random beats
// against an in-bench observer predictor, with random sender gaps and receiver stalls.
// Depends on dpo_pkg and the observer RTL only.
module delayed_position_observer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpo_pkg::*;

  localparam int HIST_DEPTH = 16;
  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;
  localparam logic signed [31:0] WordMax = 32'sh7fffffff;
  localparam logic signed [31:0] WordMin = 32'sh80000000;

  typedef enum logic [1:0] {StallNone, StallSparse, StallLong} stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  dpo_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  dpo_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // predictor configuration and state
  logic [15:0] cfg_dt = SamplePeriodRst;
  logic signed [31:0] k_pos = '0;
  logic signed [31:0] k_vel = '0;
  logic signed [31:0] k_bias = '0;
  logic signed [31:0] decay_rate = '0;
  logic [3:0] delay_cfg = '0;
  logic signed [31:0] est_pos = '0;
  logic signed [31:0] est_vel = '0;
  logic signed [31:0] est_bias = '0;
  logic signed [31:0] pos_hist [HIST_DEPTH];
  int unsigned hist_idx = 0;

  dpo_in_t beat_q [$];
  dpo_out_t estimate_q [$];
  int pending_beats = 0;
  int fail_count = 0;

  int tx_gap_left = 0;
  int tx_burst_left = 0;
  stall_mode_e stall_mode = StallNone;
  int mode_left = 0;
  int stall_left = 0;
  dpo_out_t want;

  delayed_position_observer_top #(
    .MAX_DELAY(HIST_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return WordMax;
    if (x < -64'sd2147483648) return WordMin;
    return x[31:0];
  endfunction

  // floor((x + 2^(s-1)) / 2^s)
  function automatic longint round_shift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] apply_gain(logic signed [31:0] x,
                                                    logic signed [31:0] g,
                                                    logic signed [31:0] e, longint dt);
    logic signed [31:0] ke;
    ke = clamp32(round_shift(longint'(g) * longint'(e), 16));
    return clamp32(longint'(x) + round_shift(longint'(ke) * dt, 16));
  endfunction

  function automatic void observe_step(dpo_in_t b);
    longint acc, meas, dt, h, k;
    logic signed [31:0] u, e;
    int unsigned d;
    dpo_out_t r;
    acc = b.acceleration;
    meas = b.measured_position;
    dt = cfg_dt;
    d = (delay_cfg > HIST_DEPTH - 1) ? HIST_DEPTH - 1 : delay_cfg;
    if (hist_idx >= HIST_DEPTH) hist_idx = 0;
    h = round_shift(acc * dt, 17);
    u = clamp32(longint'(est_vel) + h);
    est_pos = clamp32(longint'(est_pos) + round_shift(dt * longint'(u), 16));
    est_vel = clamp32(longint'(est_vel) + round_shift(dt * acc, 16));
    k = clamp32(round_shift(dt * longint'(decay_rate), 16));
    est_bias = clamp32(longint'(est_bias) - round_shift(k * longint'(est_bias), 16));
    pos_hist[hist_idx] = est_pos;
    hist_idx++;
    if (hist_idx > d || hist_idx >= HIST_DEPTH) hist_idx = 0;
    e = clamp32(meas - longint'(pos_hist[hist_idx]));
    est_pos = apply_gain(est_pos, k_pos, e, dt);
    est_vel = apply_gain(est_vel, k_vel, e, dt);
    est_bias = apply_gain(est_bias, k_bias, e, dt);
    r.position_estimate = est_pos;
    r.velocity_estimate = est_vel;
    r.bias_estimate = est_bias;
    estimate_q.push_back(r);
  endfunction

  task automatic report_field(string field, logic signed [31:0] want_v,
                              logic signed [31:0] got_v);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
  endtask

  // sender: bursts of beats separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        observe_step(in_data_i);
        pending_beats--;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          in_valid_i <= 1'b0;
        end else if (beat_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= beat_q.pop_front();
          if (tx_burst_left > 0) begin
            tx_burst_left--;
          end else begin
            tx_gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            tx_burst_left = $urandom_range(1, 24);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result beat, stall on its own pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (estimate_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat, expected none, actual %0d %0d %0d", $time,
                 out_data_o.position_estimate, out_data_o.velocity_estimate,
                 out_data_o.bias_estimate);
      end else begin
        want = estimate_q.pop_front();
        if (want.position_estimate !== out_data_o.position_estimate)
          report_field("position_estimate", want.position_estimate,
                       out_data_o.position_estimate);
        if (want.velocity_estimate !== out_data_o.velocity_estimate)
          report_field("velocity_estimate", want.velocity_estimate,
                       out_data_o.velocity_estimate);
        if (want.bias_estimate !== out_data_o.bias_estimate)
          report_field("bias_estimate", want.bias_estimate, out_data_o.bias_estimate);
      end
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(50, 400);
    end
    mode_left--;
    case (stall_mode)
      StallNone: begin
        out_stall_i <= 1'b0;
      end
      StallSparse: begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_stall_i <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(1, 40);
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    endcase
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgSamplePeriod: cfg_dt = val[15:0];
      CfgGainPosition: k_pos = val;
      CfgGainVelocity: k_vel = val;
      CfgGainBias:     k_bias = val;
      CfgBiasDecay:    decay_rate = val;
      CfgDelaySteps:   delay_cfg = val[3:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [15:0] dt, logic signed [31:0] gp, logic signed [31:0] gv,
                             logic signed [31:0] gb, logic signed [31:0] wa, logic [3:0] dly);
    logic [31:0] extra;
    extra = $urandom();
    write_reg(CfgSamplePeriod, {extra[31:16], dt});
    write_reg(CfgGainPosition, gp);
    write_reg(CfgGainVelocity, gv);
    write_reg(CfgGainBias, gb);
    write_reg(CfgBiasDecay, wa);
    write_reg(CfgDelaySteps, {extra[31:4], dly});
  endtask

  task automatic push_beat(logic signed [31:0] acc, logic signed [31:0] meas);
    dpo_in_t b;
    b.acceleration = acc;
    b.measured_position = meas;
    beat_q.push_back(b);
    pending_beats++;
  endtask

  task automatic drain();
    while (pending_beats != 0 || estimate_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_span(int unsigned span);
    return clamp32(longint'($urandom_range(0, 2 * span)) - longint'(span));
  endfunction

  // mostly a plausible trajectory with sensor noise, some full-range noise
  task automatic random_phase(int n);
    logic [15:0] dt;
    longint tp, tv, a;
    logic signed [31:0] acc_w, meas_w;
    tp = 0;
    tv = 0;
    if ($urandom_range(0, 2) != 0) begin
      dt = 16'($urandom_range(100, 3000));
      load_config(dt, rand_span(1 << 22), rand_span(1 << 22), rand_span(1 << 20),
                  rand_span(1 << 20), 4'($urandom_range(0, 15)));
    end else begin
      case ($urandom_range(0, 2))
        0: dt = 16'd1;
        1: dt = 16'hffff;
        default: dt = 16'($urandom_range(1, 65535));
      endcase
      load_config(dt, $urandom(), $urandom(), $urandom(), $urandom(),
                  4'($urandom_range(0, 15)));
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        a = longint'($urandom_range(0, 1 << 20)) - (1 << 19) - (tv >>> 3) - (tp >>> 6);
        acc_w = clamp32(a);
        tv = clamp32(tv + round_shift(longint'(acc_w) * longint'(dt), 16));
        tp = clamp32(tp + round_shift(tv * longint'(dt), 16));
        meas_w = clamp32(tp + longint'($urandom_range(0, 1 << 15)) - (1 << 14));
      end else begin
        acc_w = $urandom();
        meas_w = $urandom();
      end
      push_beat(acc_w, meas_w);
    end
    drain();
  endtask

  initial begin
    foreach (pos_hist[i]) pos_hist[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings; unused register indexes must leave them alone
    write_reg(CfgSpareA, $urandom());
    write_reg(CfgSpareB, $urandom());
    push_beat(32'sd0, 32'sd0);
    push_beat(WordMax, WordMax);
    push_beat(WordMin, WordMin);
    push_beat(-32'sd1, 32'sd1);
    push_beat(32'sd1, -32'sd1);
    drain();

    // largest period, extreme gains, longest delay: saturation everywhere
    load_config(16'hffff, WordMax, WordMin, WordMax, WordMin, 4'd15);
    push_beat(WordMax, WordMin);
    push_beat(WordMin, WordMax);
    push_beat(WordMax, WordMax);
    push_beat(WordMin, WordMin);
    push_beat(32'sd0, 32'sd0);
    push_beat(32'sd1, -32'sd1);
    push_beat(WordMax, 32'sd0);
    push_beat(WordMin, 32'sd0);
    push_beat(32'sd0, WordMin);
    drain();

    // shorten the delay below the ring position, zero period
    load_config(16'd0, 32'sh00010000, -32'sh00010000, 32'sh00010000, 32'sh00010000, 4'd2);
    push_beat(WordMax, WordMax);
    push_beat(WordMin, 32'sd123456);
    push_beat(32'sd0, -32'sd1);
    push_beat(32'sd12345, WordMin);
    drain();

    load_config(16'd1, WordMin, WordMax, WordMin, WordMax, 4'd15);
    push_beat(WordMax, WordMin);
    push_beat(WordMin, WordMax);
    push_beat(32'sh00010000, 32'sh7fff0000);
    push_beat(-32'sh00010000, 32'sd0);
    drain();

    for (int p = 0; p < 12; p++) random_phase(137);

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[delayed_position_observer_top] OK");
    end else begin
      $display("[delayed_position_observer_top] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[delayed_position_observer_top] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
sv/dpo_pkg.sv
sv/dpo_ring.sv
sv/delayed_position_observer_top.sv
verif/delayed_position_observer_top_tb.sv
